// ----- src/vldm_pkg.sv -----
// Shared types and codes for the virtual LAN delivery matcher.
// No dependencies; compile before every other file of the block.
package vldm_pkg;

    localparam int SRC_W      = 4;   // width of a source node index
    localparam int OUT_IDX_W  = 4;   // width of a result node index
    localparam int RESULT_CAP = 16;  // most results one message may cause
    localparam int FOUND_W    = 5;   // counts 0 .. RESULT_CAP

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_MSG = 1'b1;

    localparam logic [1:0] ATYPE_STATION = 2'd0;
    localparam logic [1:0] ATYPE_BCAST   = 2'd1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
    localparam logic [1:0] STATUS_NO_SRC   = 2'd3;

    // Control and query broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        eval;       // latch this cycle's match into the hit flag
        logic        shift;      // move hit flags one cell toward cell 0
        logic        wr;         // write the entry selected by wr_idx
        logic        station;    // 1 station match, 0 subnet broadcast
        logic [31:0] addr;       // node address on write, destination on eval
        logic [31:0] mask;       // node mask on write
        logic [15:0] port;       // node port on write, destination on eval
        logic [31:0] src_subnet; // subnet of the sending node
        logic [15:0] src_port;   // port of the sending node
    } vldm_ctl_t;

endpackage

// ----- src/vldm_if.sv -----
// Valid/ready channel interfaces for the delivery matcher's input and result
// transactions. No dependencies.
interface vldm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] ip_addr;
    logic [31:0] subnet_mask;
    logic [15:0] net_port;
    logic [3:0]  source_node;
    logic [1:0]  addr_type;

    modport source (output valid, kind, ip_addr, subnet_mask, net_port, source_node,
                    addr_type, input ready);
    modport sink   (input valid, kind, ip_addr, subnet_mask, net_port, source_node,
                    addr_type, output ready);
endinterface

interface vldm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] node_index;
    logic       delivered;
    logic [1:0] status;
    logic       last;

    modport source (output valid, node_index, delivered, status, last, input ready);
    modport sink   (input valid, node_index, delivered, status, last, output ready);
endinterface

// ----- src/vldm_cell.sv -----
// One node slot of the delivery matcher: holds a table entry, evaluates it
// against a message and passes its hit flag to the lower neighbor.
// Depends on vldm_pkg.
module vldm_cell #(
    parameter int MAX_NODES = 16,
    parameter int IDX       = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vldm_pkg::vldm_ctl_t               ctl,
    input  logic [$clog2(MAX_NODES)-1:0]      wr_idx,
    input  logic [$clog2(MAX_NODES+1)-1:0]    count,
    input  logic [vldm_pkg::SRC_W-1:0]        src,
    input  logic                              next_hit,
    output logic                              hit,
    output logic [31:0]                       entry_subnet,
    output logic [15:0]                       entry_port
);
    import vldm_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    logic [31:0] addr_reg;
    logic [31:0] mask_reg;
    logic [31:0] subnet_reg;
    logic [15:0] port_reg;
    logic        hit_reg;
    logic        hit_next;

    logic        in_table;
    logic        not_src;
    logic [31:0] host;
    logic        dir_bcast;
    logic        station_hit;
    logic        bcast_hit;

    assign host        = ~mask_reg;
    assign dir_bcast   = (ctl.addr & host) == host;
    assign station_hit = (dir_bcast ? (subnet_reg == (ctl.addr & mask_reg))
                                    : (addr_reg == ctl.addr))
                         && (port_reg == ctl.port);
    assign bcast_hit   = (subnet_reg == ctl.src_subnet) && (port_reg == ctl.src_port);
    assign in_table    = CNT_W'(IDX) < count;
    assign not_src     = (IDX >= (1 << SRC_W)) || (src != SRC_W'(IDX));

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.eval)
        begin
            hit_next = in_table && not_src && (ctl.station ? station_hit : bcast_hit);
        end
        else if (ctl.shift)
        begin
            hit_next = next_hit;
        end
    end

    // Entry storage: written once when the node is added, no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.wr && (wr_idx == IDX_W'(IDX)))
        begin
            addr_reg   <= ctl.addr;
            mask_reg   <= ctl.mask;
            subnet_reg <= ctl.addr & ctl.mask;
            port_reg   <= ctl.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit          = hit_reg;
    assign entry_subnet = subnet_reg;
    assign entry_port   = port_reg;

endmodule

// ----- src/virtual_lan_delivery_match_core.sv -----
// Virtual LAN delivery matcher, top level. Depends on vldm_pkg, vldm_if, vldm_cell.
// Flow: an add or a rejected message is classified in DECIDE and then written
// to the result register; a message walks SCAN and FLUSH to its last result.
// Throughput: one transaction at a time; a message's scan shifts the hit chain
// one cell per cycle toward cell 0, held while the result register cannot push.
// Reset (rst_n, asynchronous): empties the table and the control; entries hold
// no reset value and are only read below the node count.
module virtual_lan_delivery_match_core #(
    parameter int MAX_NODES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    vldm_in_if.sink           in_ch,
    vldm_out_if.source        out_ch
);
    import vldm_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > SRC_W) ? CNT_W : SRC_W;
    localparam int NSRC  = 1 << SRC_W;

    // Sequencer: DECIDE classifies the captured transaction, SCAN walks the
    // hit chain, FLUSH releases the held result, or an empty one, marked last.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // Captured input transaction (payload, no reset).
    logic             kind_reg, kind_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      mask_reg, mask_next;
    logic [15:0]      port_reg, port_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [1:0]       type_reg, type_next;

    // Table fill and scan control.
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic [FOUND_W-1:0]   found_inc;
    logic                 pend_vld_reg, pend_vld_next;
    logic [OUT_IDX_W-1:0] pend_idx_reg, pend_idx_next;

    // Result register: parts the scan from the result channel.
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                 out_dlv_reg, out_dlv_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;

    logic            can_push;
    logic            full;
    logic            in_accept;
    vldm_ctl_t       ctl;

    // Cell row.
    logic [MAX_NODES:0] hit_chain;
    logic [31:0]        cell_subnet [MAX_NODES];
    logic [15:0]        cell_port   [MAX_NODES];
    logic [31:0]        src_subnet_tab [NSRC];
    logic [15:0]        src_port_tab   [NSRC];

    assign can_push  = !out_valid_reg || out_ch.ready;
    assign full      = count_reg == CNT_W'(MAX_NODES);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept = in_ch.valid && in_ch.ready;
    assign found_inc = found_reg + FOUND_W'(1);
    assign hit_chain[MAX_NODES] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++)
        begin : g_cell
            vldm_cell #(
                .MAX_NODES (MAX_NODES),
                .IDX       (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .wr_idx       (count_reg[IDX_W-1:0]),
                .count        (count_reg),
                .src          (src_reg),
                .next_hit     (hit_chain[g+1]),
                .hit          (hit_chain[g]),
                .entry_subnet (cell_subnet[g]),
                .entry_port   (cell_port[g])
            );
        end

        // Only the first cells can be named as a sender.
        for (g = 0; g < NSRC; g++)
        begin : g_src
            if (g < MAX_NODES)
            begin : g_used
                assign src_subnet_tab[g] = cell_subnet[g];
                assign src_port_tab[g]   = cell_port[g];
            end
            else
            begin : g_unused
                assign src_subnet_tab[g] = '0;
                assign src_port_tab[g]   = '0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        port_next       = port_reg;
        src_next        = src_reg;
        type_next       = type_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_dlv_next    = out_dlv_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        ctl.eval       = 1'b0;
        ctl.shift      = 1'b0;
        ctl.wr         = 1'b0;
        ctl.station    = (type_reg == ATYPE_STATION);
        ctl.addr       = addr_reg;
        ctl.mask       = mask_reg;
        ctl.port       = port_reg;
        ctl.src_subnet = src_subnet_tab[src_reg];
        ctl.src_port   = src_port_tab[src_reg];

        // Drop the result once the sink takes it; a push below overrides.
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = in_ch.kind;
                    addr_next  = in_ch.ip_addr;
                    mask_next  = in_ch.subnet_mask;
                    port_next  = in_ch.net_port;
                    src_next   = in_ch.source_node;
                    type_next  = in_ch.addr_type;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    if (can_push)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (full)
                        begin
                            out_idx_next    = '0;
                            out_dlv_next    = 1'b0;
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            out_idx_next    = OUT_IDX_W'(count_reg);
                            out_dlv_next    = 1'b1;
                            out_status_next = STATUS_OK;
                            ctl.wr          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (CMP_W'(src_reg) >= CMP_W'(count_reg))
                begin
                    if (can_push)
                    begin
                        out_valid_next  = 1'b1;
                        out_idx_next    = '0;
                        out_dlv_next    = 1'b0;
                        out_status_next = STATUS_NO_SRC;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if ((type_reg != ATYPE_STATION) && (type_reg != ATYPE_BCAST))
                begin
                    if (can_push)
                    begin
                        out_valid_next  = 1'b1;
                        out_idx_next    = '0;
                        out_dlv_next    = 1'b0;
                        out_status_next = STATUS_BAD_TYPE;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    // Every cell latches its match; cell 0 then holds entry 0.
                    ctl.eval      = 1'b1;
                    scan_next     = '0;
                    found_next    = '0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Hold the chain while the result register cannot take a push.
                if (can_push)
                begin
                    if (scan_reg == count_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ctl.shift = 1'b1;
                        scan_next = scan_reg + CNT_W'(1);
                        if (hit_chain[0])
                        begin
                            // Release the earlier recipient; keep this one back
                            // until it is known whether it is the last.
                            if (pend_vld_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_idx_next    = pend_idx_reg;
                                out_dlv_next    = 1'b1;
                                out_status_next = STATUS_OK;
                                out_last_next   = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_idx_next = OUT_IDX_W'(scan_reg);
                            found_next    = found_inc;
                            if (found_inc == FOUND_W'(RESULT_CAP))
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                if (can_push)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = pend_vld_reg ? pend_idx_reg : '0;
                    out_dlv_next    = pend_vld_reg;
                    out_status_next = STATUS_OK;
                    out_last_next   = 1'b1;
                    pend_vld_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        port_reg       <= port_next;
        src_reg        <= src_next;
        type_reg       <= type_next;
        pend_idx_reg   <= pend_idx_next;
        out_idx_reg    <= out_idx_next;
        out_dlv_reg    <= out_dlv_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            found_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.node_index = out_idx_reg;
    assign out_ch.delivered  = out_dlv_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.last       = out_last_reg;

    // The table never holds more nodes than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NODES))
        else $error("node count beyond table size");

    // A result that names no recipient always closes its transaction.
    a_nodlv_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_dlv_reg) |-> out_last_reg)
        else $error("undelivered result not marked last");

    // A successful add grows the table by exactly one.
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && kind_reg == KIND_ADD && can_push && !full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not advance node count");

    // The scan never runs past the table fill or the result cap.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= count_reg)
        && (found_reg < FOUND_W'(RESULT_CAP)))
        else $error("scan out of range");

endmodule

// ----- tb/tb_virtual_lan_delivery_match_core.sv -----
// Testbench for virtual_lan_delivery_match_core: a self-checking bench with a valid/ready driver,
// a result monitor and a predictor of the node table. Depends on vldm_pkg, vldm_if and the RTL.
module tb_virtual_lan_delivery_match_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vldm_pkg::*;

    localparam int TABLE_DEPTH = 16;

    // One input transaction, as the driver puts it on the bus.
    typedef struct packed {
        logic        kind;
        logic [31:0] ip_addr;
        logic [31:0] subnet_mask;
        logic [15:0] net_port;
        logic [3:0]  source_node;
        logic [1:0]  addr_type;
    } vlan_request_t;

    // One result transaction.
    typedef struct packed {
        logic [3:0] node_index;
        logic       delivered;
        logic [1:0] status;
        logic       last;
    } vlan_delivery_t;

    logic clk;
    logic rst_n;

    vldm_in_if  in_ch ();
    vldm_out_if out_ch ();

    virtual_lan_delivery_match_core #(
        .MAX_NODES (TABLE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted node table, kept in step with every accepted transaction.
    logic [31:0] node_addr   [TABLE_DEPTH];
    logic [31:0] node_mask   [TABLE_DEPTH];
    logic [31:0] node_subnet [TABLE_DEPTH];
    logic [15:0] node_port   [TABLE_DEPTH];
    int          node_count;

    // Node list as seen by the stimulus generator, so messages can aim at real nodes.
    logic [31:0] gen_addr [$];
    logic [31:0] gen_mask [$];
    logic [15:0] gen_port [$];

    vlan_request_t  pending_requests    [$];
    vlan_delivery_t expected_deliveries [$];
    vlan_request_t  on_bus;

    int issued_count;
    int accepted_count;
    int total_requests;
    int seen_results;
    int failures;

    // Address plan for random nodes: two /24 networks and one /16.
    logic [31:0] net_base [3] = '{32'h0A01_0200, 32'hC0A8_0000, 32'h0A01_0300};
    logic [31:0] net_mask [3] = '{32'hFFFF_FF00, 32'hFFFF_0000, 32'hFFFF_FF00};
    logic [15:0] port_pool [4] = '{16'hBAC0, 16'hBAC1, 16'hFFFF, 16'h0000};

    // ------------------------------------------------------------------
    // Predictor: apply one accepted transaction to the table and queue the
    // results it must cause, in order.
    // ------------------------------------------------------------------
    function automatic void predict_delivery(input vlan_request_t req);
        vlan_delivery_t res;
        int             recipients [$];
        logic [31:0]    host;
        logic           hit;

        res = '0;
        res.last = 1'b1;

        if (req.kind == KIND_ADD) begin
            // Append the node unless the table is already full.
            if (node_count >= TABLE_DEPTH) begin
                res.status = STATUS_FULL;
            end
            else begin
                node_addr[node_count]   = req.ip_addr;
                node_mask[node_count]   = req.subnet_mask;
                node_subnet[node_count] = req.ip_addr & req.subnet_mask;
                node_port[node_count]   = req.net_port;
                res.node_index = node_count[3:0];
                res.delivered  = 1'b1;
                node_count++;
            end
            expected_deliveries.push_back(res);
            return;
        end

        // The source check comes first, then the address type.
        if (int'(req.source_node) >= node_count) begin
            res.status = STATUS_NO_SRC;
            expected_deliveries.push_back(res);
            return;
        end
        if (req.addr_type != ATYPE_STATION && req.addr_type != ATYPE_BCAST) begin
            res.status = STATUS_BAD_TYPE;
            expected_deliveries.push_back(res);
            return;
        end

        for (int idx = 0; idx < node_count && recipients.size() < RESULT_CAP; idx++) begin
            if (idx == int'(req.source_node))
                continue;
            if (req.addr_type == ATYPE_STATION) begin
                // A destination with all host bits set is a directed broadcast for
                // this node and must fall in its subnet; otherwise it must be the
                // node's own address.
                host = ~node_mask[idx];
                if ((req.ip_addr & host) == host)
                    hit = (node_subnet[idx] == (req.ip_addr & node_mask[idx]));
                else
                    hit = (node_addr[idx] == req.ip_addr);
                hit = hit && (node_port[idx] == req.net_port);
            end
            else begin
                hit = (node_subnet[idx] == node_subnet[req.source_node]) &&
                      (node_port[idx] == node_port[req.source_node]);
            end
            if (hit)
                recipients.push_back(idx);
        end

        // No recipient still yields one closing result.
        if (recipients.size() == 0) begin
            expected_deliveries.push_back(res);
            return;
        end
        foreach (recipients[k]) begin
            res.node_index = recipients[k][3:0];
            res.delivered  = 1'b1;
            res.status     = STATUS_OK;
            res.last       = (k == recipients.size() - 1);
            expected_deliveries.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers: fields that the block ignores get random values.
    // ------------------------------------------------------------------
    task automatic queue_add(input logic [31:0] addr, input logic [31:0] mask,
                             input logic [15:0] port);
        vlan_request_t req;
        req.kind        = KIND_ADD;
        req.ip_addr     = addr;
        req.subnet_mask = mask;
        req.net_port    = port;
        req.source_node = 4'($urandom);
        req.addr_type   = 2'($urandom);
        pending_requests.push_back(req);
        if (gen_addr.size() < TABLE_DEPTH) begin
            gen_addr.push_back(addr);
            gen_mask.push_back(mask);
            gen_port.push_back(port);
        end
    endtask

    task automatic queue_message(input logic [1:0] atype, input logic [3:0] src,
                                 input logic [31:0] dst, input logic [15:0] port);
        vlan_request_t req;
        req.kind        = KIND_MSG;
        req.ip_addr     = dst;
        req.subnet_mask = $urandom;
        req.net_port    = port;
        req.source_node = src;
        req.addr_type   = atype;
        pending_requests.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Driver: present the next pending transaction whenever the bus is free,
    // idling now and then except in a calm stretch of the item sequence.
    // Predict at the edge where the block accepts.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : request_driver
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_delivery(on_bus);
                accepted_count++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_requests.size() != 0 &&
                    ((issued_count >= 120 && issued_count < 180) ||
                     $urandom_range(99) >= 6)) begin
                    on_bus = pending_requests.pop_front();
                    in_ch.kind        <= on_bus.kind;
                    in_ch.ip_addr     <= on_bus.ip_addr;
                    in_ch.subnet_mask <= on_bus.subnet_mask;
                    in_ch.net_port    <= on_bus.net_port;
                    in_ch.source_node <= on_bus.source_node;
                    in_ch.addr_type   <= on_bus.addr_type;
                    in_ch.valid       <= 1'b1;
                    issued_count++;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation and
    // stall the result channel now and then, except in a calm stretch.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        vlan_delivery_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_deliveries.size() == 0) begin
                    $error("unexpected result: node_index %0d delivered %0d status %0d last %0d",
                           out_ch.node_index, out_ch.delivered, out_ch.status, out_ch.last);
                    failures++;
                end
                else begin
                    want = expected_deliveries.pop_front();
                    if (out_ch.node_index !== want.node_index) begin
                        $error("node_index: expected %0d, got %0d",
                               want.node_index, out_ch.node_index);
                        failures++;
                    end
                    if (out_ch.delivered !== want.delivered) begin
                        $error("delivered: expected %0d, got %0d",
                               want.delivered, out_ch.delivered);
                        failures++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        failures++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, out_ch.last);
                        failures++;
                    end
                end
                seen_results++;
            end
            out_ch.ready <= (seen_results >= 150 && seen_results < 260) ||
                            ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for every
    // transaction and result, then report.
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int          sel;
        int          pick;
        int          net;
        logic [1:0]  atype;
        logic [3:0]  src;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [15:0] port;

        clk                = 1'b0;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_ADD;
        in_ch.ip_addr      = '0;
        in_ch.subnet_mask  = '0;
        in_ch.net_port     = '0;
        in_ch.source_node  = '0;
        in_ch.addr_type    = ATYPE_STATION;
        out_ch.ready       = 1'b0;
        node_count         = 0;
        issued_count       = 0;
        accepted_count     = 0;
        seen_results       = 0;
        failures           = 0;

        // Directed part. A message into the empty table has no valid source.
        queue_message(ATYPE_STATION, 4'd0, 32'h0A01_0205, 16'hBAC0);
        // Extreme nodes: host mask of nothing and host mask of everything.
        queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_add(32'h0000_0000, 32'h0000_0000, 16'h0000);
        // One /24 with a duplicated address, and a neighbor network.
        queue_add(32'h0A01_0205, 32'hFFFF_FF00, 16'hBAC0);
        queue_add(32'h0A01_0209, 32'hFFFF_FF00, 16'hBAC0);
        queue_add(32'h0A01_0205, 32'hFFFF_FF00, 16'hBAC0);
        queue_add(32'h0A01_0307, 32'hFFFF_FF00, 16'hBAC1);
        // Unknown source, bad address types, and unknown source winning over a bad type.
        queue_message(ATYPE_STATION, 4'd15, 32'h0A01_0205, 16'hBAC0);
        queue_message(2'd2, 4'd2, 32'h0A01_0205, 16'hBAC0);
        queue_message(2'd3, 4'd2, 32'h0A01_0205, 16'hBAC0);
        queue_message(2'd3, 4'd6, 32'h0A01_0205, 16'hBAC0);
        // Station to a single node, to a duplicated address, and a directed broadcast.
        queue_message(ATYPE_STATION, 4'd2, 32'h0A01_0205, 16'hBAC0);
        queue_message(ATYPE_STATION, 4'd3, 32'h0A01_0205, 16'hBAC0);
        queue_message(ATYPE_STATION, 4'd2, 32'h0A01_02FF, 16'hBAC0);
        // All-ones destination against the extreme nodes, on both extreme ports.
        queue_message(ATYPE_STATION, 4'd2, 32'hFFFF_FFFF, 16'hFFFF);
        queue_message(ATYPE_STATION, 4'd2, 32'hFFFF_FFFF, 16'h0000);
        // No recipient at all.
        queue_message(ATYPE_STATION, 4'd4, 32'h0102_0304, 16'h0000);
        // Subnet broadcasts: several recipients from two senders, none from the top node.
        queue_message(ATYPE_BCAST, 4'd2, 32'h0000_0000, 16'h0000);
        queue_message(ATYPE_BCAST, 4'd4, 32'hFFFF_FFFF, 16'hFFFF);
        queue_message(ATYPE_BCAST, 4'd0, 32'h0A01_0205, 16'hBAC0);
        // Zero destination reaches the all-zero node by its address.
        queue_message(ATYPE_STATION, 4'd0, 32'h0000_0000, 16'h0000);

        // Random part: mostly messages aimed at real nodes, with adds mixed in
        // so the table fills up and later adds hit the full table.
        for (int n = 0; n < 300; n++) begin
            if ($urandom_range(99) < 15) begin
                sel  = $urandom_range(9);
                net  = $urandom_range(2);
                port = port_pool[$urandom_range(3)];
                if (sel <= 5) begin
                    mask = ($urandom_range(4) == 0) ? 32'($urandom) : net_mask[net];
                    addr = (net_base[net] & mask) | (32'($urandom) & ~mask);
                end
                else if (sel <= 7) begin
                    pick = $urandom_range(gen_addr.size() - 1);
                    addr = gen_addr[pick];
                    mask = gen_mask[pick];
                    port = gen_port[pick];
                end
                else if (sel == 8) begin
                    addr = $urandom;
                    mask = $urandom;
                    port = $urandom;
                end
                else begin
                    addr = $urandom;
                    mask = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end
                queue_add(addr, mask, port);
            end
            else begin
                sel = $urandom_range(99);
                if (sel < 65)
                    atype = ATYPE_STATION;
                else if (sel < 88)
                    atype = ATYPE_BCAST;
                else
                    atype = 2'(2 + $urandom_range(1));
                if ($urandom_range(99) < 88)
                    src = 4'($urandom_range(gen_addr.size() - 1));
                else
                    src = 4'($urandom_range(15));
                pick = $urandom_range(gen_addr.size() - 1);
                sel  = $urandom_range(9);
                if (sel <= 3) begin
                    addr = gen_addr[pick];
                    port = gen_port[pick];
                end
                else if (sel <= 6) begin
                    addr = gen_addr[pick] | ~gen_mask[pick];
                    port = gen_port[pick];
                end
                else if (sel == 7) begin
                    addr = $urandom;
                    port = gen_port[pick];
                end
                else if (sel == 8) begin
                    addr = $urandom;
                    port = $urandom;
                end
                else begin
                    addr = 32'hFFFF_FFFF;
                    port = port_pool[$urandom_range(3)];
                end
                queue_message(atype, src, addr, port);
            end
        end
        total_requests = pending_requests.size();

        // Hold reset, then release it at a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to be accepted and every result to arrive.
        while (accepted_count < total_requests)
            @(posedge clk);
        while (expected_deliveries.size() != 0)
            @(posedge clk);
        // Drain: give a stray extra result time to show up.
        repeat (3 * TABLE_DEPTH) @(posedge clk);

        if (failures == 0 && expected_deliveries.size() == 0) begin
            $display("PASS virtual_lan_delivery_match_core");
        end
        else begin
            $display("FAIL virtual_lan_delivery_match_core");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL virtual_lan_delivery_match_core");
        $finish;
    end

endmodule

// ----- files.f -----
src/vldm_pkg.sv
src/vldm_if.sv
src/vldm_cell.sv
src/virtual_lan_delivery_match_core.sv
tb/tb_virtual_lan_delivery_match_core.sv
